@@ rtl/slh32_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slh32_pkg
// shared constants and types of the seeded lane hash core
// ----------------------------------------------------------------------------
package slh32_pkg;

    localparam int unsigned HASH_W     = 32;
    localparam int unsigned LANE_W     = 32;
    localparam int unsigned LANE_FIELDS = 3;
    localparam int unsigned CNT_W      = 2;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned PART_AB_W  = 16;
    localparam int unsigned PART_C_W   = 8;
    localparam int unsigned OUT_W      = HASH_W + 2 * PART_AB_W + PART_C_W;

    localparam logic [HASH_W-1:0] HASH_PRIME2 = 32'd2246822519;
    localparam logic [HASH_W-1:0] HASH_PRIME3 = 32'd3266489917;
    localparam logic [HASH_W-1:0] HASH_PRIME4 = 32'd668265263;
    localparam logic [HASH_W-1:0] HASH_PRIME5 = 32'd374761393;

    localparam int unsigned LANE_ROT = 17;
    localparam int unsigned AV_SH1   = 15;
    localparam int unsigned AV_SH2   = 13;
    localparam int unsigned AV_SH3   = 16;

    // output format codes
    typedef enum logic [CMD_W-1:0] {
        FMT_WORD   = 2'd0,
        FMT_HALVES = 2'd1,
        FMT_BYTES  = 2'd2
    } fmt_t;

endpackage

`default_nettype wire

@@ rtl/seeded_lane_hash32_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// seeded_lane_hash32_core
// seeded 32-bit short-input hash of one to three signed coordinate lanes
// ----------------------------------------------------------------------------
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+--------------------------------
// s_axis   | in        | s_axis_tvalid/tready     | tdata lanes 0..2, tuser count+cmd
// m_axis   | out       | m_axis_tvalid/tready     | tdata hash, part_a, part_b, part_c
// cfg      | in        | cfg_valid/cfg_ready      | cfg_data = hash_seed
//
// one transaction per clock sustained while m_axis_tready holds; registers in order: entry, lanes, av1, av2, output
// the entry stage forms all lane products side by side; every later stage holds
// at most one 32x32 multiplier, which sets the stage depth
// lanes at or beyond the lane count pass their stage unchanged
// valid bits travel with the data; a stage reloads when empty or when its
// successor moves, so bubbles collapse and a stall loses nothing
// rst_n clears every valid bit and the seed; payload registers are not reset
// ----------------------------------------------------------------------------
module seeded_lane_hash32_core
    import slh32_pkg::*;
#(
    parameter int unsigned MAX_LANES = 3
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    // configuration write channel
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [HASH_W-1:0]     cfg_data,
    // input stream
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [95:0]           s_axis_tdata,   // lane_0 [31:0], lane_1 [63:32], lane_2 [95:64]
    input  wire  [3:0]            s_axis_tuser,   // lane_count [1:0], cmd [3:2]
    // output stream
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata    // hash_value [31:0], part_a [47:32],
                                                  // part_b [63:48], part_c [71:64]
);

    // lanes actually present, never above the three lane fields
    localparam int unsigned NUM_LANES = (MAX_LANES < LANE_FIELDS) ? MAX_LANES : LANE_FIELDS;

    typedef struct packed {
        logic [HASH_W-1:0]                 acc;
        logic [NUM_LANES-1:0][HASH_W-1:0]  prod;
        logic [CNT_W-1:0]                  n;
        logic [CMD_W-1:0]                  cmd;
    } lane_stage_t;

    // seed register
    logic [HASH_W-1:0] seed_reg;

    // lane pipe: index 0 is the entry stage, index k+1 follows lane k
    lane_stage_t            lp_reg  [NUM_LANES+1];
    lane_stage_t            entry_next;
    lane_stage_t            lp_next [1:NUM_LANES];
    logic [NUM_LANES:0]     vld_reg;
    logic [NUM_LANES+1:0]   rdy;

    // avalanche stages
    logic                   av1_valid_reg;
    logic [HASH_W-1:0]      av1_hash_reg, av1_hash_next;
    logic [CMD_W-1:0]       av1_cmd_reg;
    logic                   av2_valid_reg;
    logic [HASH_W-1:0]      av2_hash_reg, av2_hash_next;
    logic [CMD_W-1:0]       av2_cmd_reg;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;

    logic                   out_rdy, av2_rdy, av1_rdy;
    logic [CNT_W-1:0]       cnt_clamp;

    assign cfg_ready = 1'b1;

    // ready chain from the output back to the entry
    assign out_rdy = !out_valid_reg || m_axis_tready;
    assign av2_rdy = !av2_valid_reg || out_rdy;
    assign av1_rdy = !av1_valid_reg || av2_rdy;

    always_comb
    begin
        rdy[NUM_LANES+1] = av1_rdy;
        for (int k = NUM_LANES; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // entry stage: lane count clamp, initial accumulator, lane products
    always_comb
    begin
        cnt_clamp = s_axis_tuser[CNT_W-1:0];
        if (cnt_clamp == '0)
        begin
            cnt_clamp = CNT_W'(1);
        end
        if (cnt_clamp > CNT_W'(NUM_LANES))
        begin
            cnt_clamp = CNT_W'(NUM_LANES);
        end
        entry_next.n   = cnt_clamp;
        entry_next.cmd = s_axis_tuser[CNT_W +: CMD_W];
        entry_next.acc = seed_reg + HASH_PRIME5 + {{(HASH_W-CNT_W-2){1'b0}}, cnt_clamp, 2'b00};
        for (int j = 0; j < NUM_LANES; j++)
        begin
            entry_next.prod[j] = s_axis_tdata[LANE_W*j +: LANE_W] * HASH_PRIME3;
        end
    end

    // lane rounds: add product, rotate, multiply
    always_comb
    begin
        logic [HASH_W-1:0] sum;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            lp_next[k+1] = lp_reg[k];
            sum          = lp_reg[k].acc + lp_reg[k].prod[k];
            if (CNT_W'(k) < lp_reg[k].n)
            begin
                lp_next[k+1].acc = {sum[HASH_W-LANE_ROT-1:0], sum[HASH_W-1:HASH_W-LANE_ROT]}
                                   * HASH_PRIME4;
            end
        end
    end

    // avalanche, then output formatting
    always_comb
    begin
        logic [HASH_W-1:0] x1, x2, h;
        logic [PART_AB_W-1:0] pa, pb;
        logic [PART_C_W-1:0]  pc;
        x1 = lp_reg[NUM_LANES].acc ^ (lp_reg[NUM_LANES].acc >> AV_SH1);
        av1_hash_next = x1 * HASH_PRIME2;
        x2 = av1_hash_reg ^ (av1_hash_reg >> AV_SH2);
        av2_hash_next = x2 * HASH_PRIME3;
        h  = av2_hash_reg ^ (av2_hash_reg >> AV_SH3);
        pa = '0;
        pb = '0;
        pc = '0;
        case (av2_cmd_reg)
            FMT_HALVES:
            begin
                pa = h[15:0];
                pb = h[31:16];
            end
            FMT_BYTES:
            begin
                pa = {8'd0, h[7:0]};
                pb = {8'd0, h[15:8]};
                pc = h[23:16];
            end
            default:
            begin
                pa = '0;
            end
        endcase
        out_data_next = {pc, pb, pa, h};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            vld_reg       <= '0;
            av1_valid_reg <= 1'b0;
            av2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                seed_reg <= cfg_data;
            end
            if (rdy[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 0; k < NUM_LANES; k++)
            begin
                if (rdy[k+1])
                begin
                    vld_reg[k+1] <= vld_reg[k];
                end
            end
            if (av1_rdy)
            begin
                av1_valid_reg <= vld_reg[NUM_LANES];
            end
            if (av2_rdy)
            begin
                av2_valid_reg <= av1_valid_reg;
            end
            if (out_rdy)
            begin
                out_valid_reg <= av2_valid_reg;
            end
        end
    end

    // payload registers, loaded only when a transaction moves in
    always_ff @(posedge clk)
    begin
        if (rdy[0] && s_axis_tvalid)
        begin
            lp_reg[0] <= entry_next;
        end
        for (int k = 0; k < NUM_LANES; k++)
        begin
            if (rdy[k+1] && vld_reg[k])
            begin
                lp_reg[k+1] <= lp_next[k+1];
            end
        end
        if (av1_rdy && vld_reg[NUM_LANES])
        begin
            av1_hash_reg <= av1_hash_next;
            av1_cmd_reg  <= lp_reg[NUM_LANES].cmd;
        end
        if (av2_rdy && av1_valid_reg)
        begin
            av2_hash_reg <= av2_hash_next;
            av2_cmd_reg  <= av1_cmd_reg;
        end
        if (out_rdy && av2_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // an empty pipe always takes a new transaction
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg == '0 && !av1_valid_reg && !av2_valid_reg && !out_valid_reg)
        |-> s_axis_tready)
        else $error("empty pipeline refuses input");

    // a full pipe behind a stalled output takes nothing
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg && av1_valid_reg && av2_valid_reg && out_valid_reg && !m_axis_tready)
        |-> !s_axis_tready)
        else $error("full pipeline accepts input while stalled");

    // part_c only ever carries byte 2 of the hash
    a_part_c: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[71:64] != 8'd0)
        |-> (m_axis_tdata[71:64] == m_axis_tdata[23:16]))
        else $error("part_c does not match hash byte 2");

    // part_a is zero, the low half or the low byte of the hash
    a_part_a: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid
        |-> (m_axis_tdata[47:32] == 16'd0 || m_axis_tdata[47:32] == m_axis_tdata[15:0]
             || m_axis_tdata[47:32] == {8'd0, m_axis_tdata[7:0]}))
        else $error("part_a is not a slice of the hash");
`endif

endmodule

`default_nettype wire
